// ===== src/rebacc_pkg.sv =====
package rebacc_pkg;

	localparam int NumEncodersDef = 5;
	localparam int NumEncodersMax = 8;

	localparam int ByteW  = 8;
	localparam int PinW   = 16;
	localparam int TimeW  = 32;
	localparam int CfgW   = 16;
	localparam int ValW   = 16;
	localparam int GainW  = 16;
	localparam int CodeW  = 4;
	localparam int EncIdxW = 3;

	localparam int AddrW = 4;
	localparam int DataW = 32;

	localparam logic [CfgW-1:0] DebounceRst = 16'd5;
	localparam logic [CfgW-1:0] GainRst     = 16'd400;
	localparam logic [CfgW-1:0] MaxRst      = 16'd127;

	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_GAIN     = 2'd1;
	localparam logic [1:0] REG_MAX      = 2'd2;

	localparam logic [CodeW-1:0] CODE_UP   = 4'd8;
	localparam logic [CodeW-1:0] CODE_DOWN = 4'd4;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ms;
		logic [CfgW-1:0] accel_gain;
		logic [CfgW-1:0] value_max;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [GainW-1:0] dividend;
		logic [TimeW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [GainW-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/rebacc_regs.sv =====
module rebacc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rebacc_pkg::AddrW-1:0]  paddr,
	input  logic [rebacc_pkg::DataW-1:0]  pwdata,
	output logic [rebacc_pkg::DataW-1:0]  prdata,
	output logic                          pready,
	output rebacc_pkg::cfg_t              cfg
);

	rebacc_pkg::cfg_t cfg_q;
	logic             wr_en;
	logic [1:0]       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= rebacc_pkg::DebounceRst;
			cfg_q.accel_gain  <= rebacc_pkg::GainRst;
			cfg_q.value_max   <= rebacc_pkg::MaxRst;
		end else if (wr_en) begin
			unique case (reg_sel)
				rebacc_pkg::REG_DEBOUNCE: cfg_q.debounce_ms <= pwdata[rebacc_pkg::CfgW-1:0];
				rebacc_pkg::REG_GAIN:     cfg_q.accel_gain  <= pwdata[rebacc_pkg::CfgW-1:0];
				rebacc_pkg::REG_MAX:      cfg_q.value_max   <= pwdata[rebacc_pkg::CfgW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			rebacc_pkg::REG_DEBOUNCE: prdata = rebacc_pkg::DataW'(cfg_q.debounce_ms);
			rebacc_pkg::REG_GAIN:     prdata = rebacc_pkg::DataW'(cfg_q.accel_gain);
			rebacc_pkg::REG_MAX:      prdata = rebacc_pkg::DataW'(cfg_q.value_max);
			default:                  prdata = '0;
		endcase
	end

endmodule

// ===== src/rebacc_div.sv =====
module rebacc_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rebacc_pkg::div_req_t  req,
	output rebacc_pkg::div_rsp_t  rsp
);

	localparam int QW   = rebacc_pkg::GainW;
	localparam int DW   = rebacc_pkg::TimeW;
	localparam int CntW = $clog2(QW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dvs_q;
	logic [QW-1:0]   quo_q;

	logic [DW:0]     trial;
	logic            take;
	logic [DW-1:0]   rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[QW-1]};
		take    = trial >= {1'b0, dvs_q};
		rem_nxt = take ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/rotary_encoder_bank_accel.sv =====
// an event is screened, then each encoder is scanned in turn: one whose pins are unchanged is skipped,
// one whose pins changed goes through the shared serial divider plus setup, apply, clamp
// results follow one per encoder whose position changed, at most one per cycle as the sink allows
// one event at a time: in_ready is high only when idle
// reset: positions, click times, codes, previous pins and last event time clear to zero
module rotary_encoder_bank_accel #(
	parameter int NUM_ENCODERS = rebacc_pkg::NumEncodersDef
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rebacc_pkg::AddrW-1:0]         paddr,
	input  logic [rebacc_pkg::DataW-1:0]         pwdata,
	output logic [rebacc_pkg::DataW-1:0]         prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 port_a_flagged,
	input  logic [rebacc_pkg::ByteW-1:0]         capture_a,
	input  logic                                 port_b_flagged,
	input  logic [rebacc_pkg::ByteW-1:0]         capture_b,
	input  logic [rebacc_pkg::TimeW-1:0]         now_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rebacc_pkg::EncIdxW-1:0]       encoder_index,
	output logic [rebacc_pkg::ValW-1:0]          position,
	output logic                                 last_of_run
);

	localparam int N     = NUM_ENCODERS;
	localparam int IdxW  = (N > 1) ? $clog2(N) : 1;
	localparam int CntW  = $clog2(N + 1);
	localparam int PinW  = rebacc_pkg::PinW;
	localparam int TimeW = rebacc_pkg::TimeW;
	localparam int ValW  = rebacc_pkg::ValW;
	localparam int CodeW = rebacc_pkg::CodeW;
	localparam int GainW = rebacc_pkg::GainW;
	localparam int StepW = GainW + 1;
	localparam int RawW  = ValW + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DIV,
		ST_APPLY,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	rebacc_pkg::cfg_t     cfg;
	rebacc_pkg::div_req_t div_req;
	rebacc_pkg::div_rsp_t div_rsp;

	state_t               state_q;
	logic [CntW-1:0]      idx_q;
	logic [N-1:0]         mask_q;
	logic [PinW-1:0]      word_q;
	logic [PinW-1:0]      old_q;
	logic [TimeW-1:0]     now_q;
	logic [PinW-1:0]      prev_pins_q;
	logic [TimeW-1:0]     last_accept_q;
	logic [ValW-1:0]      pos_q   [N];
	logic [TimeW-1:0]     click_q [N];
	logic [CodeW-1:0]     acc_q   [N];
	logic [CodeW-1:0]     code_q;
	logic [TimeW-1:0]     divisor_q;
	logic                 div_start_q;
	logic [RawW-1:0]      raw_q;
	logic                 neg_q;

	logic [IdxW-1:0]      sel;
	logic                 at_end;
	logic [PinW-1:0]      in_word;
	logic [TimeW-1:0]     since_accept;
	logic                 drop;
	logic [1:0]           new_pair;
	logic [1:0]           old_pair;
	logic [TimeW-1:0]     elapsed;
	logic [StepW-1:0]     step;
	logic [CodeW-1:0]     eff_code;
	logic [ValW-1:0]      clamped;
	logic [N-1:0]         sel_bit;

	rebacc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign div_req.start    = div_start_q;
	assign div_req.dividend = cfg.accel_gain;
	assign div_req.divisor  = divisor_q;

	rebacc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		sel          = idx_q[IdxW-1:0];
		at_end       = idx_q == CntW'(N);
		in_word      = {port_b_flagged ? capture_b : 8'd0, port_a_flagged ? capture_a : 8'd0};
		since_accept = now_q - last_accept_q;
		drop         = (word_q == prev_pins_q) ||
		               (since_accept < TimeW'(cfg.debounce_ms));
		new_pair     = word_q[{sel, 1'b0} +: 2];
		old_pair     = old_q[{sel, 1'b0} +: 2];
		elapsed      = now_q - click_q[sel];
		step         = StepW'(div_rsp.quotient) + StepW'(1);
		eff_code     = ((div_rsp.quotient != '0) && (code_q != acc_q[sel])) ? acc_q[sel] : code_q;
		if (neg_q) begin
			clamped = '0;
		end else if (raw_q > RawW'(cfg.value_max)) begin
			clamped = cfg.value_max;
		end else begin
			clamped = raw_q[ValW-1:0];
		end
		sel_bit      = N'(1) << sel;
	end

	assign in_ready      = state_q == ST_IDLE;
	assign out_valid     = (state_q == ST_EMIT) && !at_end && mask_q[sel];
	assign encoder_index = rebacc_pkg::EncIdxW'(sel);
	assign position      = pos_q[sel];
	assign last_of_run   = (mask_q & ~sel_bit) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			mask_q        <= '0;
			word_q        <= '0;
			old_q         <= '0;
			now_q         <= '0;
			prev_pins_q   <= '0;
			last_accept_q <= '0;
			code_q        <= '0;
			divisor_q     <= '0;
			div_start_q   <= 1'b0;
			raw_q         <= '0;
			neg_q         <= 1'b0;
			for (int i = 0; i < N; i++) begin
				pos_q[i]   <= '0;
				click_q[i] <= '0;
				acc_q[i]   <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						word_q  <= in_word;
						now_q   <= now_ms;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (drop) begin
						state_q <= ST_IDLE;
					end else begin
						old_q         <= prev_pins_q;
						prev_pins_q   <= word_q;
						last_accept_q <= now_q;
						idx_q         <= '0;
						mask_q        <= '0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (at_end) begin
						idx_q   <= '0;
						state_q <= (mask_q == '0) ? ST_IDLE : ST_EMIT;
					end else if (new_pair == old_pair) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						code_q      <= {new_pair, old_pair};
						divisor_q   <= (elapsed == '0) ? TimeW'(1) : elapsed;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					code_q <= eff_code;
					if (eff_code == rebacc_pkg::CODE_UP) begin
						raw_q <= RawW'(pos_q[sel]) + RawW'(step);
						neg_q <= 1'b0;
					end else if (eff_code == rebacc_pkg::CODE_DOWN) begin
						raw_q <= RawW'(pos_q[sel]) - RawW'(step);
						neg_q <= RawW'(step) > RawW'(pos_q[sel]);
					end else begin
						raw_q <= RawW'(pos_q[sel]);
						neg_q <= 1'b0;
					end
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (clamped != pos_q[sel]) begin
						pos_q[sel]   <= clamped;
						click_q[sel] <= now_q;
						acc_q[sel]   <= code_q;
						mask_q       <= mask_q | sel_bit;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_SCAN;
				end
				ST_EMIT: begin
					if (at_end) begin
						state_q <= ST_IDLE;
					end else if (!mask_q[sel]) begin
						idx_q <= idx_q + 1'b1;
					end else if (out_ready) begin
						mask_q <= mask_q & ~sel_bit;
						idx_q  <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
